// ----- sv/flsp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flsp_pkg
// Shared widths, register indexes and types of the flap lever position block.
// ----------------------------------------------------------------------------
package flsp_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int CAL_W     = 13;
    localparam int LEVEL_W   = 3;
    localparam int POS_W     = 11;
    localparam int TENTHS_W  = 6;
    localparam int NUM_CAL   = 7;
    localparam int CFG_IDX_W = 3;

    localparam int SAMPLE_MAX   = 4096;
    localparam int FILTER_SHIFT = 2;     // filter gain 1/4
    localparam int DECIMATE     = 5;
    localparam int TENTHS_SCALE = 10;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_0       = 3'd1;

    // datapath widths of the mapping
    localparam int STEP_W    = CAL_W + 1;   // signed segment step
    localparam int NUM_W     = 18;          // signed numerator before clamp
    localparam int UNUM_W    = 16;          // clamped numerator
    localparam int DIV_W     = 24;          // dividend and shifted divisor
    localparam int FRAC_BITS = 8;
    localparam int POS_QBITS = POS_W;
    localparam int TEN_QBITS = TENTHS_W;
    localparam int CNT_W     = 4;

    typedef struct packed {
        logic [POS_W-1:0]    pos;
        logic [TENTHS_W-1:0] tenths;
        logic                changed;
    } flsp_result_t;

endpackage

// ----- sv/flsp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flsp_front
// Saturates samples, runs the first-order filter and picks every fifth value.
// ----------------------------------------------------------------------------
module flsp_front
    import flsp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                q_full,
    output logic                q_push,
    output logic [CAL_W-1:0]    q_data
);

    localparam logic [2:0] LAST_PHASE = 3'(DECIMATE - 1);

    logic [CAL_W-1:0]        filt_reg, filt_next;
    logic [2:0]              phase_reg, phase_next;
    logic [CAL_W-1:0]        x_sat;
    logic signed [STEP_W-1:0] diff, diff_q;
    logic                    accept;

    assign in_stall = (phase_reg == LAST_PHASE) && q_full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        x_sat = (sample > SAMPLE_W'(SAMPLE_MAX)) ? CAL_W'(SAMPLE_MAX) : sample[CAL_W-1:0];
        diff  = $signed({1'b0, x_sat}) - $signed({1'b0, filt_reg});
        // division by 4 truncating toward zero
        if (diff < 0)
        begin
            diff_q = (diff + STEP_W'(3)) >>> FILTER_SHIFT;
        end
        else
        begin
            diff_q = diff >>> FILTER_SHIFT;
        end
        filt_next  = filt_reg + diff_q[CAL_W-1:0];
        phase_next = (phase_reg == LAST_PHASE) ? 3'd0 : phase_reg + 3'd1;
    end

    assign q_push = accept && (phase_reg == LAST_PHASE);
    assign q_data = filt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg  <= '0;
            phase_reg <= '0;
        end
        else if (accept)
        begin
            filt_reg  <= filt_next;
            phase_reg <= phase_next;
        end
    end

endmodule

// ----- sv/flsp_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flsp_fifo
// Small register queue of filtered readings between front and back.
// ----------------------------------------------------------------------------
module flsp_fifo #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue written while full");
    no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue read while empty");
    count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// ----- sv/flsp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flsp_back
// Maps a filtered reading to a lever position: segment search, exact
// fraction, clamp and two shift-subtract divisions into the output register.
// ----------------------------------------------------------------------------
module flsp_back
    import flsp_pkg::*;
#(
    parameter int NLEV = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [LEVEL_W-1:0] n_levels,
    input  logic [CAL_W-1:0]   cal [NLEV],
    input  logic               q_empty,
    input  logic [CAL_W-1:0]   q_data,
    output logic               q_pop,
    input  logic               out_stall,
    output logic               out_valid,
    output flsp_result_t       result
);

    localparam int WK_W = $clog2(NLEV);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SEL   = 3'd1;
    localparam logic [2:0] ST_NUM   = 3'd2;
    localparam logic [2:0] ST_CLAMP = 3'd3;
    localparam logic [2:0] ST_POS   = 3'd4;
    localparam logic [2:0] ST_TEN   = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    logic [2:0]               state_reg;
    logic [CAL_W-1:0]         v_reg;
    logic [WK_W-1:0]          wk_reg;
    logic [CAL_W-1:0]         base_reg;
    logic signed [STEP_W-1:0] step_reg;
    logic signed [NUM_W-1:0]  snum_reg;
    logic [CAL_W-1:0]         den_reg;
    logic [UNUM_W-1:0]        num_reg;
    logic [DIV_W-1:0]         rem_reg, dsr_reg;
    logic [POS_QBITS-1:0]     q_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [TENTHS_W-1:0]      last_tenths_reg;
    logic                     out_valid_reg;
    flsp_result_t             result_reg;

    // segment search
    logic                     small_n;
    logic [LEVEL_W-1:0]       n_m1;
    logic [WK_W-1:0]          last_idx, first_idx, wk_sel, s_idx;
    logic                     desc, hit;
    logic signed [STEP_W-1:0] step_raw, step_sel;

    assign small_n  = (n_levels < LEVEL_W'(2));
    assign n_m1     = n_levels - 1'b1;
    assign last_idx = small_n ? '0 : WK_W'(n_m1);
    assign desc     = cal[0] > cal[last_idx];

    always_comb
    begin
        hit       = 1'b0;
        first_idx = '0;
        for (int i = 0; i < NLEV; i++)
        begin
            if (!hit && (LEVEL_W'(i) < n_levels) &&
                (desc ? (v_reg > cal[i]) : (v_reg < cal[i])))
            begin
                hit       = 1'b1;
                first_idx = WK_W'(i);
            end
        end
        if (hit)
        begin
            wk_sel = (first_idx == '0) ? '0 : first_idx - 1'b1;
        end
        else
        begin
            wk_sel = last_idx;
        end
        // the last position reuses the step of the segment before it
        s_idx    = (wk_sel == last_idx && wk_sel != '0) ? wk_sel - 1'b1 : wk_sel;
        step_raw = $signed({1'b0, cal[WK_W'(s_idx + 1'b1)]}) - $signed({1'b0, cal[s_idx]});
        if (step_raw == '0)
        begin
            step_sel = desc ? -STEP_W'(1) : STEP_W'(1);
        end
        else
        begin
            step_sel = step_raw;
        end
    end

    // numerator wk*step + (v - cal_wk), sign folded into the numerator
    logic signed [NUM_W-1:0] prod, offs, snum;
    logic [CAL_W-1:0]        den_abs;

    always_comb
    begin
        prod = $signed({{(NUM_W - WK_W){1'b0}}, wk_reg}) *
               $signed({{(NUM_W - STEP_W){step_reg[STEP_W-1]}}, step_reg});
        offs = $signed({{(NUM_W - CAL_W){1'b0}}, v_reg}) -
               $signed({{(NUM_W - CAL_W){1'b0}}, base_reg});
        snum = prod + offs;
        if (step_reg < 0)
        begin
            snum    = -snum;
            den_abs = CAL_W'(-step_reg);
        end
        else
        begin
            den_abs = CAL_W'(step_reg);
        end
    end

    logic [UNUM_W-1:0] lim, num_cl;

    always_comb
    begin
        lim = UNUM_W'(n_m1) * UNUM_W'(den_reg);
        if (snum_reg < 0)
        begin
            num_cl = '0;
        end
        else if (snum_reg > $signed({{(NUM_W - UNUM_W){1'b0}}, lim}))
        begin
            num_cl = lim;
        end
        else
        begin
            num_cl = snum_reg[UNUM_W-1:0];
        end
    end

    // one quotient bit per cycle
    logic             sub_ok;
    logic [DIV_W-1:0] rem_sub;

    assign sub_ok  = (rem_reg >= dsr_reg);
    assign rem_sub = sub_ok ? rem_reg - dsr_reg : rem_reg;

    logic                load_out;
    logic [TENTHS_W-1:0] tenths_q;

    assign tenths_q = q_reg[TENTHS_W-1:0];
    assign load_out = (state_reg == ST_FIN) && (!out_valid_reg || !out_stall);
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                v_reg <= q_data;
            end
            ST_SEL:
            begin
                wk_reg   <= wk_sel;
                base_reg <= cal[wk_sel];
                step_reg <= step_sel;
            end
            ST_NUM:
            begin
                snum_reg <= small_n ? '0 : snum;
                den_reg  <= small_n ? CAL_W'(1) : den_abs;
            end
            ST_CLAMP:
            begin
                num_reg <= num_cl;
                rem_reg <= DIV_W'(num_cl) << FRAC_BITS;
                dsr_reg <= DIV_W'(den_reg) << (POS_QBITS - 1);
                q_reg   <= '0;
            end
            ST_POS:
            begin
                if (cnt_reg == '0)
                begin
                    pos_reg <= {q_reg[POS_QBITS-2:0], sub_ok};
                    rem_reg <= DIV_W'(num_reg) * DIV_W'(TENTHS_SCALE);
                    dsr_reg <= DIV_W'(den_reg) << (TEN_QBITS - 1);
                    q_reg   <= '0;
                end
                else
                begin
                    rem_reg <= rem_sub;
                    dsr_reg <= dsr_reg >> 1;
                    q_reg   <= {q_reg[POS_QBITS-2:0], sub_ok};
                end
            end
            ST_TEN:
            begin
                rem_reg <= rem_sub;
                dsr_reg <= dsr_reg >> 1;
                q_reg   <= {q_reg[POS_QBITS-2:0], sub_ok};
            end
            ST_FIN:
            begin
                if (load_out)
                begin
                    result_reg.pos     <= pos_reg;
                    result_reg.tenths  <= tenths_q;
                    result_reg.changed <= (tenths_q != last_tenths_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            last_tenths_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !load_out)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        state_reg <= ST_SEL;
                    end
                end
                ST_SEL:
                begin
                    state_reg <= ST_NUM;
                end
                ST_NUM:
                begin
                    state_reg <= ST_CLAMP;
                end
                ST_CLAMP:
                begin
                    cnt_reg   <= CNT_W'(POS_QBITS - 1);
                    state_reg <= ST_POS;
                end
                ST_POS:
                begin
                    if (cnt_reg == '0)
                    begin
                        cnt_reg   <= CNT_W'(TEN_QBITS - 1);
                        state_reg <= ST_TEN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_TEN:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_FIN:
                begin
                    if (load_out)
                    begin
                        out_valid_reg   <= 1'b1;
                        last_tenths_reg <= tenths_q;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    logic [POS_W-1:0] pos_lim;
    assign pos_lim = small_n ? '0 : (POS_W'(n_m1) << FRAC_BITS);

    pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (result_reg.pos <= pos_lim))
        else $error("lever position beyond last calibrated level");
    last_tracks_out: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (last_tenths_reg == result_reg.tenths))
        else $error("last tenths not updated with reported value");
    pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg == ST_SEL))
        else $error("queue popped outside idle");

endmodule

// ----- sv/flap_sensor_lever_position.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flap_sensor_lever_position
// Flap sensor filtering and piecewise linear lever position calibration.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / sample) takes one ADC sample per
//   transaction, one per cycle while the two-entry queue has room. Every
//   fifth sample the filtered reading enters the queue; in_stall rises only
//   when that fifth sample finds the queue full.
//   Output channel (out_valid / out_stall / lever_position, lever_tenths,
//   changed) carries one result per five samples from an output register.
//   From the fifth sample to out_valid the steps are: queue pop, segment
//   search, numerator, clamp, the shift-subtract divider that produces the
//   Q3.8 position and then the tenths, and the output load. The mapping
//   unit takes one reading at a time and pops the next only when idle.
//   The mapping unit starts the next reading while a result waits; a held
//   out_stall finally backs up into the queue and then into in_stall.
//   Configuration: cfg_write with cfg_index 0 (level_count) or 1..7 (cal_0..
//   cal_6), taken at once; write only while idle.
//   Reset clears filter, sample phase, last tenths and all calibration.
// ----------------------------------------------------------------------------
module flap_sensor_lever_position
    import flsp_pkg::*;
#(
    parameter int MAX_LEVELS = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [SAMPLE_W-1:0]  sample,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [POS_W-1:0]     lever_position,
    output logic [TENTHS_W-1:0]  lever_tenths,
    output logic                 changed,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CAL_W-1:0]     cfg_data
);

    localparam int NLEV    = (MAX_LEVELS < NUM_CAL) ? MAX_LEVELS : NUM_CAL;
    localparam int Q_DEPTH = 2;

    logic [LEVEL_W-1:0] level_count_reg;
    logic [CAL_W-1:0]   cal_reg [NLEV];
    logic [LEVEL_W-1:0] n_levels;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_count_reg <= '0;
            for (int i = 0; i < NLEV; i++)
            begin
                cal_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_LEVEL_COUNT)
            begin
                level_count_reg <= cfg_data[LEVEL_W-1:0];
            end
            // entries past the usable level count are never read
            for (int i = 0; i < NLEV; i++)
            begin
                if (cfg_index == CFG_IDX_W'(REG_CAL_0 + i))
                begin
                    cal_reg[i] <= cfg_data;
                end
            end
        end
    end

    assign n_levels = (level_count_reg > LEVEL_W'(NLEV)) ? LEVEL_W'(NLEV) : level_count_reg;

    logic             q_push, q_pop, q_full, q_empty;
    logic [CAL_W-1:0] q_wdata, q_rdata;
    flsp_result_t     result;

    flsp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sample   (sample),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    flsp_fifo #(
        .WIDTH (CAL_W),
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    flsp_back #(
        .NLEV (NLEV)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .n_levels  (n_levels),
        .cal       (cal_reg),
        .q_empty   (q_empty),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .result    (result)
    );

    assign lever_position = result.pos;
    assign lever_tenths   = result.tenths;
    assign changed        = result.changed;

endmodule

// ----- tb/flsp_lever_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flsp_lever_checker
// Watches the sample, result and register ports of the flap lever position
// block, keeps its own filter, decimation and calibration state, predicts
// each lever result and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module flsp_lever_checker
    import flsp_pkg::*;
#(
    parameter int MAX_LEVELS = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [SAMPLE_W-1:0]  sample,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [POS_W-1:0]     lever_position,
    input  logic [TENTHS_W-1:0]  lever_tenths,
    input  logic                 changed,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CAL_W-1:0]     cfg_data,
    input  logic                 run_done,
    output int                   mismatches,
    output int                   outstanding,
    output int                   results_checked
);

    logic [LEVEL_W-1:0]  level_q;
    logic [CAL_W-1:0]    cal_q [NUM_CAL];
    logic [CAL_W-1:0]    filt_q;
    logic [2:0]          phase_q;
    logic [TENTHS_W-1:0] last_tenths_q;
    flsp_result_t        expected_levers [$];
    int                  fail_count;

    assign mismatches = fail_count;

    task automatic report_mismatch(input string what, input int got, input int want);
        // keep the log short if the block is badly off
        if (fail_count < 100)
            $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
        fail_count++;
    endtask

    // Exact clamped position as num / den, den > 0.
    function automatic void lever_fraction(input int v, output longint num,
                                           output longint den);
        int n;
        int wk;
        int s;
        int prev;
        int stp [NUM_CAL];
        bit desc;
        bit found;
        n = int'(level_q);
        if (n > MAX_LEVELS)
            n = MAX_LEVELS;
        if (n > NUM_CAL)
            n = NUM_CAL;
        if (n < 2)
        begin
            num = 0;
            den = 1;
            return;
        end
        desc = cal_q[0] > cal_q[n-1];
        prev = 0;
        for (int i = 0; i < n - 1; i++)
        begin
            s = int'(cal_q[i+1]) - int'(cal_q[i]);
            if (s == 0)
                s = desc ? -1 : 1;
            stp[i] = s;
            prev   = s;
        end
        stp[n-1] = prev;
        // first entry past the reading picks the segment below it
        wk    = n - 1;
        found = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if (!found && (desc ? (v > int'(cal_q[i])) : (v < int'(cal_q[i]))))
            begin
                wk    = i - 1;
                found = 1'b1;
            end
        end
        if (wk < 0)
            wk = 0;
        den = stp[wk];
        num = longint'(wk) * den + (longint'(v) - longint'(cal_q[wk]));
        if (den < 0)
        begin
            den = -den;
            num = -num;
        end
        if (num < 0)
            num = 0;
        if (num > longint'(n - 1) * den)
            num = longint'(n - 1) * den;
    endfunction

    // Advances filter and decimation; returns 1 when a lever result is due.
    function automatic bit predict_lever(input logic [SAMPLE_W-1:0] raw,
                                         output flsp_result_t res);
        int     x;
        int     f;
        longint num;
        longint den;
        longint q;
        x = (raw > SAMPLE_MAX) ? SAMPLE_MAX : int'(raw);
        f = int'(filt_q);
        f = f + (x - f) / 4;     // truncates toward zero
        filt_q  = f[CAL_W-1:0];
        phase_q = phase_q + 3'd1;
        res = '0;
        if (phase_q < DECIMATE)
            return 1'b0;
        phase_q = 3'd0;
        lever_fraction(int'(filt_q), num, den);
        q = (num * 256) / den;
        res.pos = q[POS_W-1:0];
        q = (num * TENTHS_SCALE) / den;
        res.tenths  = q[TENTHS_W-1:0];
        res.changed = (res.tenths != last_tenths_q);
        if (res.changed)
            last_tenths_q = res.tenths;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        flsp_result_t want;
        if (!rst_n)
        begin
            level_q       = '0;
            filt_q        = '0;
            phase_q       = '0;
            last_tenths_q = '0;
            for (int i = 0; i < NUM_CAL; i++)
                cal_q[i] = '0;
            expected_levers.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_LEVEL_COUNT)
                    level_q = cfg_data[LEVEL_W-1:0];
                else
                    cal_q[int'(cfg_index) - int'(REG_CAL_0)] = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                if (predict_lever(sample, want))
                    expected_levers.insert(expected_levers.size(), want);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_levers.size() == 0)
                    report_mismatch("lever result with none expected",
                                    int'(lever_position), 0);
                else
                begin
                    want = expected_levers.pop_front();
                    if (lever_position !== want.pos)
                        report_mismatch("lever_position", int'(lever_position),
                                        int'(want.pos));
                    if (lever_tenths !== want.tenths)
                        report_mismatch("lever_tenths", int'(lever_tenths),
                                        int'(want.tenths));
                    if (changed !== want.changed)
                        report_mismatch("changed", int'(changed), int'(want.changed));
                    results_checked++;
                end
            end
            outstanding <= expected_levers.size();
        end
    end

    always @(posedge run_done)
    begin
        if (expected_levers.size() != 0)
            report_mismatch("lever results never delivered",
                            expected_levers.size(), 0);
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives flap sensor samples and calibration tables into the lever position
// block under several sender idle and receiver stall mixes; the checker beside
// the block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb;
    import flsp_pkg::*;

    localparam int MAX_LEVELS    = 7;
    localparam int SETTLE_CYCLES = 48;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 112;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [SAMPLE_W-1:0]  sample;
    logic                 out_valid;
    logic                 out_stall;
    logic [POS_W-1:0]     lever_position;
    logic [TENTHS_W-1:0]  lever_tenths;
    logic                 changed;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CAL_W-1:0]     cfg_data;
    logic                 run_done;

    int mismatches;
    int outstanding;
    int results_checked;
    int idle_pct;
    int stall_pct;
    int samples_sent;
    int settings_loaded;

    logic [LEVEL_W-1:0] lc_set;
    logic [CAL_W-1:0]   cal_set [NUM_CAL];

    flap_sensor_lever_position #(
        .MAX_LEVELS(MAX_LEVELS)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample         (sample),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .lever_position (lever_position),
        .lever_tenths   (lever_tenths),
        .changed        (changed),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    flsp_lever_checker #(
        .MAX_LEVELS(MAX_LEVELS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .sample          (sample),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .lever_position  (lever_position),
        .lever_tenths    (lever_tenths),
        .changed         (changed),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .run_done        (run_done),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

    initial
    begin
        #2_000_000;
        $display("timeout: lever results stopped arriving");
        $display("Some tests failed");
        $finish;
    end

    task automatic set_mode(input int mode);
        case (mode)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 66; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 66; end
            default: begin idle_pct = 20; stall_pct = 20; end
        endcase
    endtask

    // Called at a clock edge; returns at the edge that takes the transaction.
    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        in_valid <= 1'b1;
        sample   <= value;
        do
            @(posedge clk);
        while (in_stall);
        samples_sent++;
    endtask

    // Let every pending result out, then give the mapping time to go idle.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings();
        logic [31:0] junk;
        junk = $urandom;
        // upper bits of the count write are don't-care
        cfg_write <= 1'b1;
        cfg_index <= REG_LEVEL_COUNT;
        cfg_data  <= {junk[CAL_W-LEVEL_W-1:0], lc_set};
        @(posedge clk);
        for (int i = 0; i < NUM_CAL; i++)
        begin
            cfg_index <= REG_CAL_0 + CFG_IDX_W'(i);
            cfg_data  <= cal_set[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        settings_loaded++;
    endtask

    task automatic pick_settings(input int kind);
        int v;
        int n;
        int pick;
        n = $urandom_range(7, 2);
        case (kind)
            0:
            begin
                // ascending, with the odd flat segment
                v = $urandom_range(1500, 0);
                for (int i = 0; i < NUM_CAL; i++)
                begin
                    cal_set[i] = CAL_W'(v);
                    v += ($urandom_range(3) == 0) ? 0 : $urandom_range(800, 1);
                    if (v > SAMPLE_MAX)
                        v = SAMPLE_MAX;
                end
            end
            1:
            begin
                v = $urandom_range(SAMPLE_MAX, 2600);
                for (int i = 0; i < NUM_CAL; i++)
                begin
                    cal_set[i] = CAL_W'(v);
                    v -= ($urandom_range(3) == 0) ? 0 : $urandom_range(800, 1);
                    if (v < 0)
                        v = 0;
                end
            end
            2:
                for (int i = 0; i < NUM_CAL; i++)
                    cal_set[i] = CAL_W'($urandom_range(8191, 0));
            3:
            begin
                n = $urandom_range(1, 0);
                for (int i = 0; i < NUM_CAL; i++)
                    cal_set[i] = CAL_W'($urandom_range(SAMPLE_MAX, 0));
            end
            4:
            begin
                // all flat, or flat but for the first entry
                v = $urandom_range(SAMPLE_MAX, 0);
                for (int i = 0; i < NUM_CAL; i++)
                    cal_set[i] = CAL_W'(v);
                if ($urandom_range(1))
                    cal_set[0] = CAL_W'($urandom_range(SAMPLE_MAX, 0));
            end
            default:
            begin
                n = MAX_LEVELS;
                for (int i = 0; i < NUM_CAL; i++)
                begin
                    pick = $urandom_range(3);
                    case (pick)
                        0:       cal_set[i] = '0;
                        1:       cal_set[i] = CAL_W'(SAMPLE_MAX);
                        2:       cal_set[i] = '1;
                        default: cal_set[i] = CAL_W'($urandom_range(8191, 0));
                    endcase
                end
            end
        endcase
        lc_set = LEVEL_W'(n);
    endtask

    // Level the filter should settle near: mostly around a table entry.
    function automatic int pick_target();
        int r;
        int t;
        r = $urandom_range(9);
        if (r <= 5)
            t = int'(cal_set[$urandom_range(NUM_CAL - 1)]) + $urandom_range(60) - 30;
        else if (r == 6)
            t = $urandom_range(SAMPLE_MAX, 0);
        else if (r == 7)
            t = $urandom_range(1) ? SAMPLE_MAX : 0;
        else
            t = $urandom_range(65535, SAMPLE_MAX + 1);
        if (t < 0)
            t = 0;
        return t;
    endfunction

    task automatic run_random_phase();
        int sent;
        int target;
        int run_len;
        int s;
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            target  = pick_target();
            run_len = $urandom_range(20, 3);
            for (int k = 0; k < run_len && sent < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(11) == 0)
                    s = $urandom_range(65535, 0);
                else
                    s = target + $urandom_range(6) - 3;
                if (s < 0)
                    s = 0;
                if (s > 65535)
                    s = 65535;
                send_sample(SAMPLE_W'(s));
                sent++;
            end
        end
    endtask

    initial
    begin
        logic [SAMPLE_W-1:0] reset_corner [10];
        reset_corner = '{16'd0, 16'hFFFF, 16'd4096, 16'd4097, 16'd4095,
                         16'h8000, 16'h5555, 16'hAAAA, 16'd1, 16'h7FFF};
        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        sample          <= '0;
        out_stall       <= 1'b0;
        cfg_write       <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        run_done        <= 1'b0;
        idle_pct        = 0;
        stall_pct       = 0;
        samples_sent    = 0;
        settings_loaded = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset calibration (no positions in use): sample corners
        set_mode(0);
        foreach (reset_corner[i])
            send_sample(reset_corner[i]);
        drain_results();

        // evenly spaced ascending table, filter swept full scale and back
        lc_set = 3'd7;
        for (int i = 0; i < NUM_CAL; i++)
            cal_set[i] = CAL_W'((i * SAMPLE_MAX) / 6);
        load_settings();
        set_mode(3);
        repeat (5) send_sample(16'hFFFF);
        repeat (5) send_sample(16'd0);
        repeat (5) send_sample(16'd2048);
        drain_results();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            pick_settings(p % 6);
            load_settings();
            set_mode(p % 4);
            run_random_phase();
            drain_results();
        end

        run_done <= 1'b1;
        repeat (3) @(posedge clk);
        $display("Covered %0d samples over %0d calibration tables and four idle/stall mixes",
                 samples_sent, settings_loaded);
        $display("%0d lever results compared, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
